// File: hdl/wfm_pkg.sv
package wfm_pkg;

	localparam int MASK_CHARS = 16;
	localparam int POS_W      = MASK_CHARS + 1;
	localparam int CHAR_W     = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int MASK_REGS  = 4;
	localparam int MASK_IDX_W = 2;
	localparam int LEN_W      = 5;

	localparam logic [CHAR_W-1:0] CH_STAR  = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_QMARK = 16'h003F;
	localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;

	localparam logic [POS_W-1:0] ACT_INIT = POS_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_LOW      = 3'd0,
		REG_MASK_MID_LOW  = 3'd1,
		REG_MASK_MID_HIGH = 3'd2,
		REG_MASK_HIGH     = 3'd3,
		REG_MASK_LENGTH   = 3'd4
	} cfg_reg_t;

	// decoded mask, one bit per mask position unless noted
	typedef struct packed {
		logic [MASK_CHARS-1:0][CHAR_W-1:0] chars;
		logic [MASK_CHARS-1:0] in_use;        // position below effective length
		logic [MASK_CHARS-1:0] is_star;
		logic [MASK_CHARS-1:0] is_qmark;
		logic [MASK_CHARS-1:0] star_next;     // star with a char after it
		logic [MASK_CHARS-1:0] last_star;     // star as last char
		logic [MASK_CHARS-1:0] star_dot_tail; // star of a trailing "*."
		logic [MASK_CHARS-1:0] dot_tail;      // dot of a trailing "." or ".*"
		logic [POS_W-1:0]      len_oh;        // effective length, one-hot
	} mask_info_t;

	typedef struct packed {
		logic              go;     // item leaves the input stage
		logic              is_end;
		logic [CHAR_W-1:0] ch;
	} nfa_step_t;

endpackage

// File: hdl/wildcard_filename_match.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------
// input     | in_valid / in_stall    | name_char, end_of_name
// result    | out_valid / out_stall  | matched
// config    | cfg_wr_en              | cfg_index, cfg_wr_data
//
// One item per cycle sustained while in_stall is low. An end item gives its result
// through the input stage, then the result register; character items give none.
// The mask decode is registered: a config write is seen by items transferred
// from the following cycle on.
// Reset clears the mask registers, the length and the position set (position 0 live).
// A result held by out_stall keeps the input stage open for character items; only
// an end item waiting behind a held result raises in_stall.
module wildcard_filename_match
	import wfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAR_W-1:0]     name_char,
	input  logic                  end_of_name,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  matched
);

	mask_info_t        info;
	nfa_step_t         step;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;
	logic              out_valid_q;
	logic              matched_q;
	logic              out_free;
	logic              adv;
	logic              match;

	wfm_mask_regs u_mask_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.info        (info)
	);

	// result register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// character items never need the result register
	assign adv      = valid_s1 && (!end_s1 || out_free);
	assign in_stall = valid_s1 && !adv;

	assign step.go     = adv;
	assign step.is_end = end_s1;
	assign step.ch     = char_s1;

	wfm_nfa u_nfa (
		.clk    (clk),
		.arst_n (arst_n),
		.info   (info),
		.step   (step),
		.match  (match)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= name_char;
			end_s1  <= end_of_name;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) begin
			matched_q <= match;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && end_s1 && out_valid_q && out_stall))
		else $error("input stalled without an end item blocked by a held result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && end_s1))
		else $error("result appeared without an end item");

endmodule

// File: hdl/wfm_mask_regs.sv
module wfm_mask_regs
	import wfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	output mask_info_t            info
);

	logic [MASK_REGS-1:0][CFG_DATA_W-1:0] mask_q;
	logic [LEN_W-1:0]                     len_q;
	logic [MASK_REGS*CFG_DATA_W-1:0]      mask_flat;
	logic [LEN_W-1:0]                     lim;
	mask_info_t                           info_d;
	mask_info_t                           info_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			len_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MASK_LOW, REG_MASK_MID_LOW, REG_MASK_MID_HIGH, REG_MASK_HIGH: begin
					mask_q[cfg_index[MASK_IDX_W-1:0]] <= cfg_wr_data;
				end
				REG_MASK_LENGTH: begin
					len_q <= cfg_wr_data[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign mask_flat = mask_q;
	assign lim = (len_q > LEN_W'(MASK_CHARS)) ? LEN_W'(MASK_CHARS) : len_q;

	always_comb begin
		logic run;
		logic [POS_W-1:0] prev_use;
		logic [POS_W-1:0] cur_use;
		info_d = '0;
		run = 1'b1;
		for (int i = 0; i < MASK_CHARS; i++) begin
			info_d.chars[i]    = mask_flat[i*CHAR_W +: CHAR_W];
			run                = run & (info_d.chars[i] != CH_NUL);
			info_d.in_use[i]   = run & (LEN_W'(i) < lim);
			info_d.is_star[i]  = info_d.chars[i] == CH_STAR;
			info_d.is_qmark[i] = info_d.chars[i] == CH_QMARK;
		end
		// first unused position marks the effective length
		prev_use = {info_d.in_use, 1'b1};
		cur_use  = {1'b0, info_d.in_use};
		info_d.len_oh = prev_use & ~cur_use;
		for (int i = 0; i < MASK_CHARS; i++) begin
			info_d.last_star[i] = info_d.in_use[i] & info_d.is_star[i] & info_d.len_oh[i+1];
			info_d.dot_tail[i]  = info_d.in_use[i] & (info_d.chars[i] == CH_DOT) &
				info_d.len_oh[i+1];
			if (i + 1 < MASK_CHARS) begin
				info_d.star_next[i] = info_d.in_use[i] & info_d.is_star[i] &
					info_d.in_use[i+1];
				info_d.star_dot_tail[i] = info_d.star_next[i] &
					(info_d.chars[i+1] == CH_DOT) & info_d.len_oh[i+2];
				if (info_d.in_use[i] && info_d.chars[i] == CH_DOT &&
					info_d.in_use[i+1] && info_d.is_star[i+1] && info_d.len_oh[i+2]) begin
					info_d.dot_tail[i] = 1'b1;
				end
			end
		end
	end

	// decode held in flops, refreshed from the mask and length registers
	always_ff @(posedge clk) begin
		info_q <= info_d;
	end

	assign info = info_q;

endmodule

// File: hdl/wfm_nfa.sv
module wfm_nfa
	import wfm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mask_info_t info,
	input  nfa_step_t  step,
	output logic       match
);

	logic [POS_W-1:0]      active_q;
	logic                  early_q;
	logic                  nodot_q;
	logic                  started_q;
	logic                  start_early;
	logic                  start_nodot;
	logic [MASK_CHARS-1:0] keep;
	logic [MASK_CHARS-1:0] lit_hit;
	logic [MASK_CHARS-1:0] skip_hit;
	logic [POS_W-1:0]      nxt;
	logic [POS_W-1:0]      ent;
	logic                  ent_early;
	logic                  ent_nodot;

	// position zero entered at the first item of a name
	assign start_early = !started_q & active_q[0] & info.last_star[0];
	assign start_nodot = !started_q & active_q[0] & info.star_dot_tail[0];

	always_comb begin
		for (int i = 0; i < MASK_CHARS; i++) begin
			keep[i]    = active_q[i] & info.star_next[i];
			lit_hit[i] = active_q[i] & info.in_use[i] & !info.is_star[i] &
				(info.is_qmark[i] | (step.ch == info.chars[i]));
			skip_hit[i] = 1'b0;
			if (i + 1 < MASK_CHARS) begin
				skip_hit[i] = keep[i] & (step.ch == info.chars[i+1]);
			end
		end
	end

	assign ent = ({1'b0, lit_hit} << 1) | ({1'b0, skip_hit} << 2);
	assign nxt = {1'b0, keep} | ent;
	assign ent_early = |(ent[MASK_CHARS-1:0] & info.last_star);
	assign ent_nodot = |(ent[MASK_CHARS-1:0] & info.star_dot_tail);

	assign match = early_q | start_early | nodot_q | start_nodot |
		(|(active_q & info.len_oh)) | (|(active_q[MASK_CHARS-1:0] & info.dot_tail));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACT_INIT;
			early_q   <= 1'b0;
			nodot_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (step.go) begin
			if (step.is_end) begin
				active_q  <= ACT_INIT;
				early_q   <= 1'b0;
				nodot_q   <= 1'b0;
				started_q <= 1'b0;
			end else begin
				active_q  <= nxt;
				early_q   <= early_q | start_early | ent_early;
				nodot_q   <= ((nodot_q | start_nodot) & (step.ch != CH_DOT)) | ent_nodot;
				started_q <= 1'b1;
			end
		end
	end

	a_idle_init: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (active_q == ACT_INIT))
		else $error("position set not at start while no name in progress");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step.go && step.is_end) |=>
			(active_q == ACT_INIT && !early_q && !nodot_q && !started_q))
		else $error("state not cleared after end item");

endmodule
